FILE: design/trapezoidal_cell_timing_core_defines.svh
// assertion macros shared by the trapezoidal cell timing design
`ifndef TRAPEZOIDAL_CELL_TIMING_CORE_DEFINES_SVH
`define TRAPEZOIDAL_CELL_TIMING_CORE_DEFINES_SVH

// same-cycle implication
`define TCC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcc check failed");

// next-cycle implication
`define TCC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcc check failed");

`endif

FILE: design/tcc_pkg.sv
// types and constants of the trapezoidal cell timing design
package tcc_pkg;

  localparam int LEN_W    = 10;
  localparam int CFG_W    = 16;
  localparam int SPEED_W  = 16;
  localparam int ACCEL_W  = 16;
  localparam int BODY_W   = 12;
  localparam int TIME_W   = 24;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 2;

  // distances in 1/512 cell
  localparam int DIST_W = LEN_W + 9;
  localparam int PROD_W = DIST_W + ACCEL_W;
  localparam int SQ_W   = 2 * SPEED_W;
  localparam int SUM_W  = ((PROD_W > SQ_W + 1) ? PROD_W : SQ_W + 1) + 1;
  localparam int QUO_W  = DIST_W + 17;
  localparam int NUM_W  = SUM_W + 7;
  localparam int DEN_W  = 2 * SPEED_W;

  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = (QUO_W + 1) / 2;
  localparam int SQRT_IN_W  = 2 * SQRT_STEPS;
  localparam int ROOT_W     = SQRT_STEPS;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic [INDEX_W-1:0] REG_TOP_SPEED   = 2'd0;
  localparam logic [INDEX_W-1:0] REG_ACCEL_RATE  = 2'd1;
  localparam logic [INDEX_W-1:0] REG_BODY_LENGTH = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_ZERO_RATE,
    ST_BEYOND
  } status_t;

  typedef struct packed {
    status_t status;
    logic    trap;
    logic    t_root;
    logic    t_lin;
    logic    e_root;
    logic    e_lin;
  } side_t;

endpackage

FILE: design/tcc_req_if.sv
// request channel: path length and cell number
interface tcc_req_if import tcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] path_cells;
  logic [LEN_W-1:0] cell_number;

  modport source(output valid, path_cells, cell_number, input ready);
  modport sink(input valid, path_cells, cell_number, output ready);
endinterface

FILE: design/tcc_rsp_if.sv
// response channel: the three times and a status code
interface tcc_rsp_if import tcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   touch_time;
  logic [TIME_W-1:0]   sweep_time;
  logic [TIME_W-1:0]   total_time;
  logic [STATUS_W-1:0] status;

  modport source(output valid, touch_time, sweep_time, total_time, status, input ready);
  modport sink(input valid, touch_time, sweep_time, total_time, status, output ready);
endinterface

FILE: design/trapezoidal_cell_timing_core.sv
// trapezoidal cell timing core: touch, sweep and arrival times for one cell of a run
// path: a word accepted passes stages a, b, c, the bit-per-stage divider and root
// pipelines, stage f1 and the output buffer, whose two words absorb a stalled sink
// throughput: one word per cycle while the output buffer has a free slot
// reset: synchronous, clears all valid bits and the buffer; registers return to 256 each
`include "trapezoidal_cell_timing_core_defines.svh"

module trapezoidal_cell_timing_core import tcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  tcc_req_if.sink            req,
  tcc_rsp_if.source          rsp
);

  localparam int SB_LEN = DIV_STEPS + SQRT_STEPS;
  localparam logic [DIST_W-1:0] HALF_CELL = DIST_W'(256);

  // configuration registers
  logic [SPEED_W-1:0] top_speed;
  logic [ACCEL_W-1:0] accel_rate;
  logic [BODY_W-1:0]  body_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_speed   <= SPEED_W'(256);
      accel_rate  <= ACCEL_W'(256);
      body_length <= BODY_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOP_SPEED:   top_speed   <= cfg_data[SPEED_W-1:0];
        REG_ACCEL_RATE:  accel_rate  <= cfg_data[ACCEL_W-1:0];
        REG_BODY_LENGTH: body_length <= cfg_data[BODY_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves while the output buffer has a free slot
  logic [1:0] cnt;
  logic       adv;
  assign adv       = (cnt != 2'd2);
  assign req.ready = adv;

  // stage a: status and the two distances
  logic [DIST_W-1:0] in_pos, in_d, in_off, in_xt, in_xe, in_exit;
  status_t           in_status;

  always_comb begin
    in_pos  = DIST_W'(req.cell_number) << 9;
    in_d    = DIST_W'(req.path_cells) << 9;
    in_off  = HALF_CELL + DIST_W'(body_length);
    in_exit = in_pos + HALF_CELL;
    // front touches half a cell before the cell, less the body length
    in_xt   = (in_pos > in_off) ? in_pos - in_off : '0;
    if (req.cell_number == req.path_cells) begin
      in_xe = in_d;
    end else begin
      in_xe = (in_exit > DIST_W'(body_length)) ? in_exit - DIST_W'(body_length) : '0;
    end
    if (in_xt > in_d) in_xt = in_d;
    if (in_xe > in_d) in_xe = in_d;
    if (top_speed == '0 || accel_rate == '0) begin
      in_status = ST_ZERO_RATE;
    end else if (req.cell_number > req.path_cells) begin
      in_status = ST_BEYOND;
    end else begin
      in_status = ST_OK;
    end
  end

  logic              a_v, b_v, c_v;
  status_t           a_status, b_status;
  logic [DIST_W-1:0] a_d, a_xt, a_xe, b_d, b_xt, b_xe;

  // stage b: products
  logic [SQ_W-1:0]   b_vv, b_av;
  logic [PROD_W-1:0] b_ad, b_axt, b_axe;

  // stage c: case flags and divider operands
  side_t            c_side;
  logic [NUM_W-1:0] c_num_t, c_num_e, c_num_end, c_num_r2d;
  logic [DEN_W-1:0] c_den_t, c_den_e, c_den_end, c_den_r2d;

  function automatic logic [SUM_W-1:0] ext_sum(input logic [PROD_W-1:0] p);
    ext_sum = SUM_W'(p);
  endfunction

  logic              cx_trap;
  logic              ct_lt, ce_lt, ct_root, ce_root, ct_lin, ce_lin;
  logic [DIST_W-1:0] ct_y, ce_y;
  logic [SUM_W-1:0]  ct_sum, ce_sum, c_vv2, c_end_sum;

  always_comb begin
    c_vv2     = SUM_W'({b_vv, 1'b0});
    cx_trap   = c_vv2 <= ext_sum(b_ad);
    c_end_sum = c_vv2 + ext_sum(b_ad);
    ct_sum    = ext_sum(b_axt) + SUM_W'(b_vv);
    ce_sum    = ext_sum(b_axe) + SUM_W'(b_vv);
    ct_lt     = ext_sum(b_axt) < SUM_W'(b_vv);
    ce_lt     = ext_sum(b_axe) < SUM_W'(b_vv);
    // root from the start, either while accelerating or in the first half of a triangle
    ct_root   = cx_trap ? ct_lt : ({b_xt, 1'b0} < {1'b0, b_d});
    ce_root   = cx_trap ? ce_lt : ({b_xe, 1'b0} < {1'b0, b_d});
    // cruise section
    ct_lin    = cx_trap && !ct_lt && (ct_sum < ext_sum(b_ad));
    ce_lin    = cx_trap && !ce_lt && (ce_sum < ext_sum(b_ad));
    ct_y      = ct_root ? b_xt : b_d - b_xt;
    ce_y      = ce_root ? b_xe : b_d - b_xe;
  end

  // pipeline registers ahead of the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else if (adv) begin
      a_v <= req.valid;
      b_v <= a_v;
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_status <= in_status;
      a_d      <= in_d;
      a_xt     <= in_xt;
      a_xe     <= in_xe;

      b_status <= a_status;
      b_d      <= a_d;
      b_xt     <= a_xt;
      b_xe     <= a_xe;
      b_vv     <= SQ_W'(top_speed * top_speed);
      b_av     <= SQ_W'(accel_rate * top_speed);
      b_ad     <= PROD_W'(accel_rate * a_d);
      b_axt    <= PROD_W'(accel_rate * a_xt);
      b_axe    <= PROD_W'(accel_rate * a_xe);

      c_side.status <= b_status;
      c_side.trap   <= cx_trap;
      c_side.t_root <= ct_root;
      c_side.t_lin  <= ct_lin;
      c_side.e_root <= ce_root;
      c_side.e_lin  <= ce_lin;
      c_num_t   <= ct_lin ? NUM_W'(ct_sum) << 7 : NUM_W'(ct_y) << 16;
      c_den_t   <= ct_lin ? b_av : DEN_W'(accel_rate);
      c_num_e   <= ce_lin ? NUM_W'(ce_sum) << 7 : NUM_W'(ce_y) << 16;
      c_den_e   <= ce_lin ? b_av : DEN_W'(accel_rate);
      c_num_end <= NUM_W'(c_end_sum) << 7;
      c_den_end <= b_av;
      c_num_r2d <= NUM_W'(b_d) << 17;
      c_den_r2d <= DEN_W'(accel_rate);
    end
  end

  // dividers and roots
  logic [QUO_W-1:0]  q_t, q_e, q_end, q_r2d;
  logic [ROOT_W-1:0] r_t, r_e, r_2d;

  tcc_divider u_div_t   (.clk(clk), .en(adv), .num(c_num_t),   .den(c_den_t),   .quo(q_t));
  tcc_divider u_div_e   (.clk(clk), .en(adv), .num(c_num_e),   .den(c_den_e),   .quo(q_e));
  tcc_divider u_div_end (.clk(clk), .en(adv), .num(c_num_end), .den(c_den_end), .quo(q_end));
  tcc_divider u_div_r2d (.clk(clk), .en(adv), .num(c_num_r2d), .den(c_den_r2d), .quo(q_r2d));

  tcc_isqrt u_sqrt_t  (.clk(clk), .en(adv), .radicand(SQRT_IN_W'(q_t)),   .root(r_t));
  tcc_isqrt u_sqrt_e  (.clk(clk), .en(adv), .radicand(SQRT_IN_W'(q_e)),   .root(r_e));
  tcc_isqrt u_sqrt_2d (.clk(clk), .en(adv), .radicand(SQRT_IN_W'(q_r2d)), .root(r_2d));

  // flags follow the arithmetic; quotients wait out the root stages
  logic [SB_LEN-1:0] sb_v;
  side_t             sb [SB_LEN];
  logic [QUO_W-1:0]  qd_t [SQRT_STEPS];
  logic [QUO_W-1:0]  qd_e [SQRT_STEPS];
  logic [QUO_W-1:0]  qd_end [SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_v <= '0;
    end else if (adv) begin
      sb_v <= {sb_v[SB_LEN-2:0], c_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0]     <= c_side;
      qd_t[0]   <= q_t;
      qd_e[0]   <= q_e;
      qd_end[0] <= q_end;
      for (int k = 1; k < SB_LEN; k++) begin
        sb[k] <= sb[k-1];
      end
      for (int k = 1; k < SQRT_STEPS; k++) begin
        qd_t[k]   <= qd_t[k-1];
        qd_e[k]   <= qd_e[k-1];
        qd_end[k] <= qd_end[k-1];
      end
    end
  end

  // stage f1: pick each time from its section of the profile
  side_t            fs;
  logic [QUO_W-1:0] f_base, f_tt, f_te, f_rt, f_re;

  always_comb begin
    fs     = sb[SB_LEN-1];
    f_rt   = QUO_W'(r_t);
    f_re   = QUO_W'(r_e);
    // total time: end of deceleration or apex of the triangle doubled
    f_base = fs.trap ? qd_end[SQRT_STEPS-1] : QUO_W'(r_2d);
    if (fs.t_root) begin
      f_tt = f_rt;
    end else if (fs.t_lin) begin
      f_tt = qd_t[SQRT_STEPS-1];
    end else begin
      f_tt = (f_base > f_rt) ? f_base - f_rt : '0;
    end
    if (fs.e_root) begin
      f_te = f_re;
    end else if (fs.e_lin) begin
      f_te = qd_e[SQRT_STEPS-1];
    end else begin
      f_te = (f_base > f_re) ? f_base - f_re : '0;
    end
  end

  logic             f1_v;
  status_t          f1_status;
  logic [QUO_W-1:0] f1_tt, f1_te, f1_ta;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (adv) begin
      f1_v <= sb_v[SB_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_status <= fs.status;
      f1_tt     <= f_tt;
      f1_te     <= f_te;
      f1_ta     <= f_base;
    end
  end

  // stage f2: sweep, saturation, error zeroing
  function automatic logic [TIME_W-1:0] sat_time(input logic [QUO_W-1:0] t);
    sat_time = (t > QUO_W'(TIME_MAX)) ? TIME_MAX : t[TIME_W-1:0];
  endfunction

  typedef struct packed {
    logic [TIME_W-1:0] touch;
    logic [TIME_W-1:0] sweep;
    logic [TIME_W-1:0] arrival;
    status_t           status;
  } word_t;

  word_t            fin;
  logic [QUO_W-1:0] f_sweep;

  always_comb begin
    f_sweep = (f1_te > f1_tt) ? f1_te - f1_tt : '0;
    fin.status = f1_status;
    if (f1_status == ST_OK) begin
      fin.touch   = sat_time(f1_tt);
      fin.sweep   = sat_time(f_sweep);
      fin.arrival = sat_time(f1_ta);
    end else begin
      fin.touch   = '0;
      fin.sweep   = '0;
      fin.arrival = '0;
    end
  end

  // two-word output buffer, head drives the response channel
  word_t ent0, ent1;
  logic  push, pop;

  assign push = adv && f1_v;
  assign pop  = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && cnt == 2'd1) begin
        ent0 <= fin;
      end else begin
        ent0 <= ent1;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        ent0 <= fin;
      end else begin
        ent1 <= fin;
      end
    end
  end

  assign rsp.valid      = (cnt != 2'd0);
  assign rsp.touch_time = ent0.touch;
  assign rsp.sweep_time = ent0.sweep;
  assign rsp.total_time = ent0.arrival;
  assign rsp.status     = ent0.status;

  // checks
  logic rsp_times_zero;
  assign rsp_times_zero = (rsp.touch_time == '0) && (rsp.sweep_time == '0) &&
                          (rsp.total_time == '0);

  `TCC_ASSERT_NXT(a_req_enters, clk, rst, req.valid && req.ready, a_v)
  `TCC_ASSERT_NXT(a_push_lands, clk, rst, f1_v && adv, cnt != 2'd0)
  `TCC_ASSERT_IMP(a_err_zero, clk, rst, rsp.valid && rsp.status != ST_OK, rsp_times_zero)

endmodule

FILE: design/tcc_divider.sv
// pipelined restoring divider, one quotient bit per stage
module tcc_divider import tcc_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [DEN_W-1:0] rem_r [DIV_STEPS];
  logic [DEN_W-1:0] den_r [DIV_STEPS];
  logic [QUO_W-1:0] nq_r  [DIV_STEPS];
  logic [DEN_W-1:0] rem_next [DIV_STEPS];
  logic [DEN_W-1:0] den_next [DIV_STEPS];
  logic [QUO_W-1:0] nq_next  [DIV_STEPS];

  always_comb begin
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] nq_in;
    logic [DEN_W:0]   trial;
    logic             take;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k == 0) begin
        // top bits stay below the divisor whenever the quotient is used
        rem_in = DEN_W'(num[NUM_W-1:QUO_W]);
        den_in = den;
        nq_in  = num[QUO_W-1:0];
      end else begin
        rem_in = rem_r[k-1];
        den_in = den_r[k-1];
        nq_in  = nq_r[k-1];
      end
      trial       = {rem_in, nq_in[QUO_W-1]};
      take        = trial >= {1'b0, den_in};
      rem_next[k] = take ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
      den_next[k] = den_in;
      nq_next[k]  = {nq_in[QUO_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_next;
      den_r <= den_next;
      nq_r  <= nq_next;
    end
  end

  assign quo = nq_r[DIV_STEPS-1];

endmodule

FILE: design/tcc_isqrt.sv
// pipelined integer square root, one root bit per stage
module tcc_isqrt import tcc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [SQRT_IN_W-1:0] radicand,
  output logic [ROOT_W-1:0]    root
);

  logic [SQRT_IN_W-1:0] n_r [SQRT_STEPS];
  logic [SQRT_IN_W-1:0] r_r [SQRT_STEPS];
  logic [SQRT_IN_W-1:0] n_next [SQRT_STEPS];
  logic [SQRT_IN_W-1:0] r_next [SQRT_STEPS];

  always_comb begin
    logic [SQRT_IN_W-1:0] n_in;
    logic [SQRT_IN_W-1:0] r_in;
    logic [SQRT_IN_W-1:0] bit_w;
    logic [SQRT_IN_W:0]   sum;
    logic                 take;
    for (int j = 0; j < SQRT_STEPS; j++) begin
      if (j == 0) begin
        n_in = radicand;
        r_in = '0;
      end else begin
        n_in = n_r[j-1];
        r_in = r_r[j-1];
      end
      bit_w     = SQRT_IN_W'(1) << (2 * (SQRT_STEPS - 1 - j));
      sum       = {1'b0, r_in} + {1'b0, bit_w};
      take      = {1'b0, n_in} >= sum;
      n_next[j] = take ? SQRT_IN_W'({1'b0, n_in} - sum) : n_in;
      r_next[j] = take ? (r_in >> 1) + bit_w : (r_in >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_next;
      r_r <= r_next;
    end
  end

  assign root = r_r[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

FILE: bench/tcc_timing_checker.sv
// checker for the trapezoidal cell timing core: predicts each result and compares it
`timescale 1ns / 100ps

module tcc_timing_checker import tcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  tcc_req_if                 req,
  tcc_rsp_if                 rsp,
  output int                 fails,
  output int                 pending,
  output int                 words_checked
);

  typedef struct packed {
    logic [TIME_W-1:0] touch;
    logic [TIME_W-1:0] sweep;
    logic [TIME_W-1:0] arrival;
    status_t           status;
  } timing_t;

  timing_t     timing_q[$];
  logic [15:0] speed_reg;
  logic [15:0] accel_reg;
  logic [11:0] body_reg;

  // bitwise integer square root, rounding down
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned root_ticks(longint unsigned y, longint unsigned a);
    return floor_root((y * 65536) / a);
  endfunction

  function automatic longint unsigned minus0(longint unsigned x, longint unsigned y);
    return (x > y) ? x - y : 0;
  endfunction

  // time to reach distance x (1/512 cell) on a run of length d
  function automatic longint unsigned ticks_at(longint unsigned x, longint unsigned d,
                                               longint unsigned v, longint unsigned a);
    longint unsigned vv;
    vv = v * v;
    if (2 * vv <= d * a) begin
      if (x * a < vv) return root_ticks(x, a);
      if (x * a + vv < d * a) return (128 * (vv + a * x)) / (a * v);
      return minus0((128 * (2 * vv + a * d)) / (a * v), root_ticks(d - x, a));
    end
    if (2 * x < d) return root_ticks(x, a);
    return minus0(root_ticks(2 * d, a), root_ticks(d - x, a));
  endfunction

  function automatic logic [TIME_W-1:0] clip(longint unsigned t);
    return (t > TIME_MAX) ? TIME_MAX : t[TIME_W-1:0];
  endfunction

  function automatic timing_t predict_timing(logic [LEN_W-1:0] n, logic [LEN_W-1:0] i);
    timing_t         res;
    longint unsigned d, xt, xe, tt, te;
    res = '{touch: '0, sweep: '0, arrival: '0, status: ST_OK};
    if (speed_reg == 0 || accel_reg == 0) begin
      res.status = ST_ZERO_RATE;
      return res;
    end
    if (i > n) begin
      res.status = ST_BEYOND;
      return res;
    end
    d  = longint'(n) * 512;
    xt = minus0(longint'(i) * 512, 256 + body_reg);
    xe = (i == n) ? d : minus0(longint'(i) * 512 + 256, body_reg);
    if (xt > d) xt = d;
    if (xe > d) xe = d;
    tt = ticks_at(xt, d, speed_reg, accel_reg);
    te = ticks_at(xe, d, speed_reg, accel_reg);
    res.touch   = clip(tt);
    res.sweep   = clip(minus0(te, tt));
    res.arrival = clip(ticks_at(d, d, speed_reg, accel_reg));
    return res;
  endfunction

  always @(posedge clk) begin
    timing_t want;
    if (rst) begin
      speed_reg <= 16'd256;
      accel_reg <= 16'd256;
      body_reg  <= 12'd256;
      timing_q.delete();
      fails         <= 0;
      words_checked <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TOP_SPEED:   speed_reg <= cfg_data;
          REG_ACCEL_RATE:  accel_reg <= cfg_data;
          REG_BODY_LENGTH: body_reg  <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        timing_q.push_back(predict_timing(req.path_cells, req.cell_number));
      if (rsp.valid && rsp.ready) begin
        words_checked <= words_checked + 1;
        if (timing_q.size() == 0) begin
          if (fails < 10) $display("unexpected result word at %0t", $realtime);
          fails <= fails + 1;
        end else begin
          want = timing_q.pop_front();
          if (rsp.touch_time !== want.touch || rsp.sweep_time !== want.sweep ||
              rsp.total_time !== want.arrival || rsp.status !== want.status) begin
            if (fails < 10)
              $display("mismatch: exp t=%0d s=%0d a=%0d st=%0d got t=%0d s=%0d a=%0d st=%0d",
                       want.touch, want.sweep, want.arrival, want.status,
                       rsp.touch_time, rsp.sweep_time, rsp.total_time, rsp.status);
            fails <= fails + 1;
          end
        end
      end
    end
  end

  assign pending = timing_q.size();

endmodule

FILE: bench/tb_trapezoidal_cell_timing_core.sv
// top of the trapezoidal cell timing testbench: stimulus, handshake idling and verdict
`timescale 1ns / 100ps

module tb_trapezoidal_cell_timing_core import tcc_pkg::*; ();

  localparam int LATENCY   = 4 + QUO_W + SQRT_STEPS;
  localparam int STALL_MAX = 20000;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  int                 fails;
  int                 pending;
  int                 words_checked;
  int                 send_idle_pct;
  int                 sink_idle_pct;
  int                 quiet_cycles;
  int                 cfg_sets;

  tcc_req_if req();
  tcc_rsp_if rsp();

  trapezoidal_cell_timing_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .rsp(rsp)
  );

  tcc_timing_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .rsp(rsp), .fails(fails), .pending(pending), .words_checked(words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at the current rate
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("tb_trapezoidal_cell_timing_core NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // lower valid at once, wait for every outstanding word, then let the pipe settle
  task automatic drain;
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_profile(input logic [15:0] v, input logic [15:0] a,
                             input logic [11:0] lb);
    drain();
    write_reg(REG_TOP_SPEED, v);
    write_reg(REG_ACCEL_RATE, a);
    write_reg(REG_BODY_LENGTH, {4'd0, lb});
    cfg_sets++;
  endtask

  // one request word; valid stays up across back-to-back words
  task automatic send_query(input logic [LEN_W-1:0] n, input logic [LEN_W-1:0] i);
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.path_cells  <= n;
    req.cell_number <= i;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic directed_queries;
    send_query(0, 0);
    send_query(1023, 1023);
    send_query(1023, 0);
    send_query(1023, 511);
    send_query(5, 6);          // cell past the run
    send_query(0, 1023);
    send_query(1, 0);
    send_query(1, 1);
    send_query(2, 1);
  endtask

  // random run: mostly cells on the path, some past it, mostly short runs
  task automatic random_queries(input int count);
    logic [LEN_W-1:0] n;
    logic [LEN_W-1:0] i;
    for (int k = 0; k < count; k++) begin
      n = LEN_W'(($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(40));
      case ($urandom_range(9))
        0:       i = LEN_W'($urandom_range(1023));
        1:       i = n;
        2:       i = '0;
        default: i = LEN_W'($urandom_range(n));
      endcase
      send_query(n, i);
    end
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    req.valid       = 1'b0;
    req.path_cells  = '0;
    req.cell_number = '0;
    send_idle_pct   = 8;
    sink_idle_pct   = 64;
    cfg_sets        = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset values, then at the extremes
    directed_queries();
    set_profile(16'd0, 16'd256, 12'd256);       // zero speed
    send_query(10, 3);
    send_query(10, 20);
    set_profile(16'd256, 16'd0, 12'd256);       // zero acceleration
    send_query(10, 3);
    set_profile(16'hffff, 16'hffff, 12'hfff);   // longest body, fastest profile
    directed_queries();
    set_profile(16'd1, 16'd1, 12'd0);           // crawl, saturating times
    send_query(1023, 1023);
    send_query(3, 2);

    // random part over several profiles and idling schemes
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 64;
        sink_idle_pct = 8;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        sink_idle_pct = 0;
      end
      if (ph == 0) set_profile(16'd256, 16'd256, 12'd256);
      else set_profile(16'($urandom_range(16'hffff)), 16'($urandom_range(16'hffff)),
                       12'($urandom_range(12'hfff)));
      random_queries(250);
    end

    drain();
    $display("ran %0d result words over %0d register settings", words_checked, cfg_sets);
    $display("covered zero rates, cells past the run, long bodies and saturation");
    if (fails == 0) begin
      $display("tb_trapezoidal_cell_timing_core OK");
    end else begin
      $display("tb_trapezoidal_cell_timing_core NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/tcc_pkg.sv
design/tcc_req_if.sv
design/tcc_rsp_if.sv
design/tcc_divider.sv
design/tcc_isqrt.sv
design/trapezoidal_cell_timing_core.sv
bench/tcc_timing_checker.sv
bench/tb_trapezoidal_cell_timing_core.sv
